// ===== rtl/qlfs_pkg.sv =====
// qlfs_pkg: shared types and constants of the quadrant led frame serializer
// no dependencies; used by every rtl file of the block except qlfs_ram
package qlfs_pkg;

  localparam int FRAME_SIDE_DEF = 32;
  localparam int COUNT_BITS     = 8;
  localparam int REPS_W         = 3;
  localparam int PADDR_W        = 3;
  localparam int PDATA_W        = 32;
  localparam int CNT_IDX_W      = $clog2(COUNT_BITS);
  localparam int LANES          = 4;

  localparam logic [REPS_W-1:0] REPS_RESET = REPS_W'(2);
  localparam logic REG_REPEATS = 1'b0;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PIX,
    ST_CNT
  } state_t;

  typedef enum logic [1:0] {
    KIND_IDLE,
    KIND_PIX,
    KIND_CNT
  } kind_t;

  typedef struct packed {
    logic [1:0] op;
    logic [4:0] pixel_row;
    logic [4:0] pixel_col;
    logic       pixel_on;
  } in_item_t;

  typedef struct packed {
    logic lane0_bit;
    logic lane1_bit;
    logic lane2_bit;
    logic lane3_bit;
    logic update_strobe;
    logic shifting;
    logic last;
  } out_item_t;

  typedef struct packed {
    logic                 clr;
    logic                 wr_en;
    logic [1:0]           wr_quad;
    logic                 wr_data;
    logic                 res_valid;
    kind_t                kind;
    logic [CNT_IDX_W-1:0] cnt_idx;
    logic                 upd;
    logic                 last;
    logic                 cnt_init;
  } ctrl_cmd_t;

endpackage

// ===== rtl/quadrant_led_frame_serializer_unit.sv =====
// quadrant_led_frame_serializer_unit: top level with the repeat count register
// depends on qlfs_pkg, qlfs_ctrl, qlfs_dp and qlfs_ram
//
// Every command (pixel write, start, shift tick) is taken whenever start is high
// and busy is low, so a new one may follow on every cycle while busy is low. The
// result of a tick comes out in the cycle after the tick is taken, set by the
// registered read of the four quadrant rams; it is valid for that one cycle
// only, as there is no way to hold it off. After reset busy stays high for the
// clearing pass of the frame rams, which writes all 2**(2*clog2(FRAME_SIDE/2))
// addresses of each ram, 256 at the default size; apb writes are taken during it.
module quadrant_led_frame_serializer_unit #(
  parameter int FRAME_SIDE = qlfs_pkg::FRAME_SIDE_DEF,
  localparam int H  = FRAME_SIDE / 2,
  localparam int HB = (H > 1) ? $clog2(H) : 1,
  localparam int AW = 2 * HB
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  qlfs_pkg::in_item_t           in_data,
  output logic                         out_strobe,
  output qlfs_pkg::out_item_t          out_data,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [qlfs_pkg::PADDR_W-1:0] paddr,
  input  logic [qlfs_pkg::PDATA_W-1:0] pwdata,
  output logic [qlfs_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);

  logic [qlfs_pkg::REPS_W-1:0] reps_cfg_r;
  qlfs_pkg::ctrl_cmd_t         cmd;
  logic [AW-1:0]               wr_addr;
  logic [HB-1:0]               rd_i, rd_j;
  logic                        reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == qlfs_pkg::REG_REPEATS);
  assign prdata  = reg_sel ? qlfs_pkg::PDATA_W'(reps_cfg_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reps_cfg_r <= qlfs_pkg::REPS_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      reps_cfg_r <= pwdata[qlfs_pkg::REPS_W-1:0];
    end
  end

  qlfs_ctrl #(
    .FRAME_SIDE(FRAME_SIDE)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_data      (in_data),
    .frame_repeats(reps_cfg_r),
    .busy         (busy),
    .cmd          (cmd),
    .wr_addr      (wr_addr),
    .rd_i         (rd_i),
    .rd_j         (rd_j)
  );

  qlfs_dp #(
    .FRAME_SIDE(FRAME_SIDE)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .wr_addr   (wr_addr),
    .rd_i      (rd_i),
    .rd_j      (rd_j),
    .out_strobe(out_strobe),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/qlfs_ram.sv =====
// qlfs_ram: generic single write port ram with one registered read port
// no dependencies
module qlfs_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/qlfs_ctrl.sv =====
// qlfs_ctrl: command decode, clearing pass and scan sequencer of the serializer
// depends on qlfs_pkg
module qlfs_ctrl #(
  parameter int FRAME_SIDE = qlfs_pkg::FRAME_SIDE_DEF,
  localparam int H  = FRAME_SIDE / 2,
  localparam int HB = (H > 1) ? $clog2(H) : 1,
  localparam int AW = 2 * HB
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  qlfs_pkg::in_item_t          in_data,
  input  logic [qlfs_pkg::REPS_W-1:0] frame_repeats,
  output logic                        busy,
  output qlfs_pkg::ctrl_cmd_t         cmd,
  output logic [AW-1:0]               wr_addr,
  output logic [HB-1:0]               rd_i,
  output logic [HB-1:0]               rd_j
);

  localparam logic [HB-1:0] H_LAST = HB'(H - 1);
  localparam logic [qlfs_pkg::CNT_IDX_W-1:0] N_LAST =
    qlfs_pkg::CNT_IDX_W'(qlfs_pkg::COUNT_BITS - 1);
  localparam logic [AW-1:0] CLR_LAST = '1;

  qlfs_pkg::state_t state_r, state_nxt;
  logic [AW-1:0]                     clr_r, clr_nxt;
  logic [HB-1:0]                     i_r, i_nxt, j_r, j_nxt;
  logic [qlfs_pkg::CNT_IDX_W-1:0]    n_r, n_nxt;
  logic [qlfs_pkg::REPS_W-1:0]       reps_r, reps_nxt;

  logic        accept;
  logic [31:0] row_x, col_x;
  logic        in_frame, top, right;
  logic [HB-1:0] lr, lc;

  assign busy   = (state_r == qlfs_pkg::ST_CLEAR);
  assign accept = start && !busy;
  assign rd_i   = i_r;
  assign rd_j   = j_r;

  // pixel address split into quadrant and local row/column
  assign row_x    = 32'(in_data.pixel_row);
  assign col_x    = 32'(in_data.pixel_col);
  assign in_frame = (row_x < 32'(2 * H)) && (col_x < 32'(2 * H));
  assign top      = (row_x < 32'(H));
  assign right    = (col_x >= 32'(H));
  assign lr       = top ? HB'(row_x) : HB'(row_x - 32'(H));
  assign lc       = right ? HB'(col_x - 32'(H)) : HB'(col_x);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      qlfs_pkg::ST_CLEAR: begin
        if (clr_r == CLR_LAST) state_nxt = qlfs_pkg::ST_IDLE;
      end
      qlfs_pkg::ST_IDLE: begin
        if (accept && in_data.op == qlfs_pkg::OP_START && frame_repeats != '0) begin
          state_nxt = qlfs_pkg::ST_PIX;
        end
      end
      qlfs_pkg::ST_PIX: begin
        if (accept && in_data.op == qlfs_pkg::OP_TICK && i_r == H_LAST && j_r == H_LAST) begin
          state_nxt = qlfs_pkg::ST_CNT;
        end
      end
      qlfs_pkg::ST_CNT: begin
        if (accept && in_data.op == qlfs_pkg::OP_TICK && n_r == N_LAST) begin
          state_nxt = (reps_r <= qlfs_pkg::REPS_W'(1)) ? qlfs_pkg::ST_IDLE : qlfs_pkg::ST_PIX;
        end
      end
      default: state_nxt = qlfs_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.kind = qlfs_pkg::KIND_IDLE;
    clr_nxt  = clr_r;
    i_nxt    = i_r;
    j_nxt    = j_r;
    n_nxt    = n_r;
    reps_nxt = reps_r;
    wr_addr  = {lr, lc};
    case (state_r)
      qlfs_pkg::ST_CLEAR: begin
        cmd.clr = 1'b1;
        wr_addr = clr_r;
        clr_nxt = clr_r + AW'(1);
      end
      qlfs_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_data.op)
            qlfs_pkg::OP_WRITE: begin
              cmd.wr_en   = in_frame;
              cmd.wr_quad = top ? (right ? 2'd0 : 2'd3) : (right ? 2'd1 : 2'd2);
              cmd.wr_data = in_data.pixel_on;
            end
            qlfs_pkg::OP_START: begin
              if (frame_repeats != '0) begin
                reps_nxt     = frame_repeats;
                i_nxt        = '0;
                j_nxt        = '0;
                n_nxt        = '0;
                cmd.cnt_init = 1'b1;
              end
            end
            qlfs_pkg::OP_TICK: begin
              cmd.res_valid = 1'b1;
            end
            default: ;
          endcase
        end
      end
      qlfs_pkg::ST_PIX: begin
        if (accept && in_data.op == qlfs_pkg::OP_TICK) begin
          cmd.res_valid = 1'b1;
          cmd.kind      = qlfs_pkg::KIND_PIX;
          if (j_r == H_LAST) begin
            j_nxt = '0;
            i_nxt = (i_r == H_LAST) ? '0 : i_r + HB'(1);
          end else begin
            j_nxt = j_r + HB'(1);
          end
          n_nxt = '0;
        end
      end
      qlfs_pkg::ST_CNT: begin
        if (accept && in_data.op == qlfs_pkg::OP_TICK) begin
          cmd.res_valid = 1'b1;
          cmd.kind      = qlfs_pkg::KIND_CNT;
          cmd.cnt_idx   = n_r;
          if (n_r == N_LAST) begin
            cmd.upd = 1'b1;
            n_nxt   = '0;
            if (reps_r <= qlfs_pkg::REPS_W'(1)) begin
              cmd.last = 1'b1;
              reps_nxt = '0;
            end else begin
              reps_nxt = reps_r - qlfs_pkg::REPS_W'(1);
            end
          end else begin
            n_nxt = n_r + qlfs_pkg::CNT_IDX_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= qlfs_pkg::ST_CLEAR;
      clr_r   <= '0;
      i_r     <= '0;
      j_r     <= '0;
      n_r     <= '0;
      reps_r  <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      n_r     <= n_nxt;
      reps_r  <= reps_nxt;
    end
  end

endmodule

// ===== rtl/qlfs_dp.sv =====
// qlfs_dp: quadrant frame rams, lane ones counters and result register
// depends on qlfs_pkg and qlfs_ram
module qlfs_dp #(
  parameter int FRAME_SIDE = qlfs_pkg::FRAME_SIDE_DEF,
  localparam int H  = FRAME_SIDE / 2,
  localparam int HB = (H > 1) ? $clog2(H) : 1,
  localparam int AW = 2 * HB
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  qlfs_pkg::ctrl_cmd_t  cmd,
  input  logic [AW-1:0]        wr_addr,
  input  logic [HB-1:0]        rd_i,
  input  logic [HB-1:0]        rd_j,
  output logic                 out_strobe,
  output qlfs_pkg::out_item_t  out_data
);

  localparam logic [HB-1:0] H_LAST = HB'(H - 1);
  localparam logic [qlfs_pkg::CNT_IDX_W-1:0] N_LAST =
    qlfs_pkg::CNT_IDX_W'(qlfs_pkg::COUNT_BITS - 1);
  localparam logic [qlfs_pkg::COUNT_BITS-1:0] CNT_ONE = qlfs_pkg::COUNT_BITS'(1);

  logic [HB-1:0] row_top, col_a, col_b;
  logic [AW-1:0] raddr [qlfs_pkg::LANES];
  logic          rbit  [qlfs_pkg::LANES];
  logic          lbit  [qlfs_pkg::LANES];

  logic                           s2_valid_r;
  qlfs_pkg::kind_t                s2_kind_r;
  logic [qlfs_pkg::CNT_IDX_W-1:0] s2_n_r;
  logic                           s2_upd_r, s2_last_r;

  // serpentine scan inside each quadrant
  assign row_top = H_LAST - rd_i;
  assign col_a   = rd_i[0] ? rd_j : H_LAST - rd_j;
  assign col_b   = rd_i[0] ? H_LAST - rd_j : rd_j;

  assign raddr[0] = {row_top, col_a};
  assign raddr[1] = {rd_i, col_a};
  assign raddr[2] = {rd_i, col_b};
  assign raddr[3] = {row_top, col_b};

  for (genvar q = 0; q < qlfs_pkg::LANES; q++) begin : g_quad
    logic we;
    logic wdata;
    logic [0:0] rdata;
    logic [qlfs_pkg::COUNT_BITS-1:0] cnt_r, cnt_nxt;

    assign we    = cmd.clr || (cmd.wr_en && cmd.wr_quad == 2'(q));
    assign wdata = cmd.clr ? 1'b0 : cmd.wr_data;

    qlfs_ram #(
      .WIDTH(1),
      .DEPTH(1 << AW)
    ) u_ram (
      .clk  (clk),
      .we   (we),
      .waddr(wr_addr),
      .wdata(wdata),
      .raddr(raddr[q]),
      .rdata(rdata)
    );

    assign rbit[q] = rdata[0];
    assign lbit[q] = (s2_kind_r == qlfs_pkg::KIND_PIX) ? rbit[q] :
                     (s2_kind_r == qlfs_pkg::KIND_CNT) ? cnt_r[N_LAST - s2_n_r] : 1'b0;

    always_comb begin
      cnt_nxt = cnt_r;
      if (s2_valid_r && s2_kind_r == qlfs_pkg::KIND_PIX) begin
        cnt_nxt = cnt_r + qlfs_pkg::COUNT_BITS'(rbit[q]);
      end else if ((s2_valid_r && s2_upd_r) || cmd.cnt_init) begin
        cnt_nxt = CNT_ONE;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cnt_r <= CNT_ONE;
      end else begin
        cnt_r <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= cmd.res_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_kind_r <= cmd.kind;
    s2_n_r    <= cmd.cnt_idx;
    s2_upd_r  <= cmd.upd;
    s2_last_r <= cmd.last;
  end

  assign out_strobe = s2_valid_r;

  always_comb begin
    out_data = '0;
    if (s2_valid_r) begin
      out_data.lane0_bit     = lbit[0];
      out_data.lane1_bit     = lbit[1];
      out_data.lane2_bit     = lbit[2];
      out_data.lane3_bit     = lbit[3];
      out_data.update_strobe = s2_upd_r;
      out_data.shifting      = (s2_kind_r != qlfs_pkg::KIND_IDLE);
      out_data.last          = s2_last_r;
    end
  end

endmodule

// ===== rtl/qlfs_checker.sv =====
// qlfs_checker: port level assertions of the serializer, bound to the top level
// depends on qlfs_pkg and quadrant_led_frame_serializer_unit
module qlfs_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         start,
  input logic                         busy,
  input qlfs_pkg::in_item_t           in_data,
  input logic                         out_strobe,
  input qlfs_pkg::out_item_t          out_data
);

  a_tick_gives_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.op == qlfs_pkg::OP_TICK) |=> out_strobe)
    else $error("tick without result beat");

  a_beat_needs_tick: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy && in_data.op == qlfs_pkg::OP_TICK))
    else $error("result beat without tick");

  a_last_on_update: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.last) |-> (out_data.update_strobe && out_data.shifting))
    else $error("last outside a count update");

  a_quiet_between: assert property (@(posedge clk) disable iff (!rst_n)
    !out_strobe |-> (out_data == '0))
    else $error("result fields active without strobe");

  a_busy_stays_low: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |=> !busy)
    else $error("busy rose after clearing pass");

endmodule

bind quadrant_led_frame_serializer_unit qlfs_checker u_qlfs_checker (.*);

// ===== tb/tb_top.sv =====
// tb_top: self-checking bench for quadrant_led_frame_serializer_unit
// depends on qlfs_pkg and the unit rtl; commands go in through start/busy, the repeat
// register through apb, and every tick beat is checked against a local prediction
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import qlfs_pkg::*;

  localparam int SIDE        = FRAME_SIDE_DEF;
  localparam int HALF        = SIDE / 2;
  localparam int PIX_TICKS   = HALF * HALF;
  localparam int TX_TICKS    = PIX_TICKS + COUNT_BITS;
  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [1:0] OP_NONE = 2'd3;
  localparam logic [PADDR_W-1:0] ADDR_REPEATS  = PADDR_W'(4 * int'(REG_REPEATS));
  localparam logic [PADDR_W-1:0] ADDR_UNMAPPED = PADDR_W'(4 * (int'(REG_REPEATS) + 1));
  localparam logic [PDATA_W-1:0] REPS_MASK     = PDATA_W'((1 << REPS_W) - 1);

  logic               clk;
  logic               rst_n   = 1'b0;
  logic               start   = 1'b0;
  logic               busy;
  in_item_t           in_data = '0;
  logic               out_strobe;
  out_item_t          out_data;
  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [PADDR_W-1:0] paddr   = '0;
  logic [PDATA_W-1:0] pwdata  = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  quadrant_led_frame_serializer_unit #(.FRAME_SIDE(SIDE)) dut (
    .clk, .rst_n, .start, .busy, .in_data, .out_strobe, .out_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // predicted state of the serializer
  bit                    pix_map [SIDE][SIDE];
  bit                    tx_on   = 1'b0;
  int unsigned           tx_pos  = 0;
  logic [REPS_W-1:0]     reps_reg  = REPS_RESET;
  logic [REPS_W-1:0]     reps_left = '0;
  logic [COUNT_BITS-1:0] lane_ones [LANES];

  out_item_t tick_beats [$];
  in_item_t  cmd_queue [$];
  int        n_queued     = 0;
  int        n_taken      = 0;
  int        n_beats_seen = 0;
  int        n_updates    = 0;
  int        n_lasts      = 0;
  int        n_reg_access = 0;
  int        n_errors     = 0;
  int        cycle_cnt    = 0;
  int        gap_left     = 0;
  bit        no_gaps      = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  function automatic void flag_error(input string what);
    n_errors++;
    if (n_errors <= 10) $display("[cycle %0d] %s", cycle_cnt, what);
  endfunction

  function automatic void run_command(input in_item_t cmd);
    out_item_t        beat;
    logic [LANES-1:0] lane_bits;
    int unsigned      row_i, col_j, top, bot, col_r, col_l, cnt_bit;
    beat = '0;
    lane_bits = '0;
    case (cmd.op)
      OP_WRITE: begin
        if (!tx_on) pix_map[cmd.pixel_row][cmd.pixel_col] = cmd.pixel_on;
      end
      OP_START: begin
        if (!tx_on && reps_reg != '0) begin
          tx_on = 1'b1;
          tx_pos = 0;
          reps_left = reps_reg;
          foreach (lane_ones[k]) lane_ones[k] = COUNT_BITS'(1);
        end
      end
      OP_TICK: begin
        if (tx_on) begin
          beat.shifting = 1'b1;
          if (tx_pos < PIX_TICKS) begin
            row_i = tx_pos / HALF;
            col_j = tx_pos % HALF;
            top   = HALF - 1 - row_i;
            bot   = HALF + row_i;
            col_r = row_i[0] ? HALF + col_j : 2 * HALF - 1 - col_j;
            col_l = row_i[0] ? HALF - 1 - col_j : col_j;
            lane_bits[0] = pix_map[top][col_r];
            lane_bits[1] = pix_map[bot][col_r];
            lane_bits[2] = pix_map[bot][col_l];
            lane_bits[3] = pix_map[top][col_l];
            foreach (lane_ones[k]) lane_ones[k] = lane_ones[k] + COUNT_BITS'(lane_bits[k]);
            tx_pos++;
          end else begin
            cnt_bit = tx_pos - PIX_TICKS;
            foreach (lane_ones[k]) lane_bits[k] = lane_ones[k][COUNT_BITS - 1 - cnt_bit];
            if (cnt_bit == COUNT_BITS - 1) begin
              beat.update_strobe = 1'b1;
              tx_pos = 0;
              if (reps_left <= 1) begin
                beat.last = 1'b1;
                tx_on = 1'b0;
                reps_left = '0;
              end else begin
                reps_left--;
                foreach (lane_ones[k]) lane_ones[k] = COUNT_BITS'(1);
              end
            end else begin
              tx_pos++;
            end
          end
        end
        beat.lane0_bit = lane_bits[0];
        beat.lane1_bit = lane_bits[1];
        beat.lane2_bit = lane_bits[2];
        beat.lane3_bit = lane_bits[3];
        tick_beats.push_back(beat);
      end
      default: ;
    endcase
  endfunction

  function automatic int pick_gap();
    int roll;
    if (no_gaps) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // command driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      gap_left <= 0;
    end else if (!start || !busy) begin
      if (gap_left > 0) begin
        start <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (cmd_queue.size() != 0) begin
        start <= 1'b1;
        in_data <= cmd_queue.pop_front();
        gap_left <= pick_gap();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor and checker
  always @(posedge clk) begin : mon
    out_item_t want;
    string     diff;
    if (rst_n) begin
      if (start && !busy) begin
        run_command(in_data);
        n_taken++;
      end
      if (psel && penable && pready) begin
        n_reg_access++;
        if (pwrite && paddr == ADDR_REPEATS) begin
          reps_reg = pwdata[REPS_W-1:0];
        end else if (!pwrite && paddr == ADDR_REPEATS && prdata !== PDATA_W'(reps_reg)) begin
          flag_error($sformatf("repeat register read: expected %0h got %0h", reps_reg, prdata));
        end
      end
      if (out_strobe) begin
        n_beats_seen++;
        if (tick_beats.size() == 0) begin
          flag_error($sformatf("tick beat %b arrived with none expected", out_data));
        end else begin
          want = tick_beats.pop_front();
          diff = "";
          if (out_data.lane0_bit !== want.lane0_bit) diff = {diff, " lane0"};
          if (out_data.lane1_bit !== want.lane1_bit) diff = {diff, " lane1"};
          if (out_data.lane2_bit !== want.lane2_bit) diff = {diff, " lane2"};
          if (out_data.lane3_bit !== want.lane3_bit) diff = {diff, " lane3"};
          if (out_data.update_strobe !== want.update_strobe) diff = {diff, " update"};
          if (out_data.shifting !== want.shifting) diff = {diff, " shifting"};
          if (out_data.last !== want.last) diff = {diff, " last"};
          if (diff != "")
            flag_error($sformatf("tick beat %0d,%s wrong: expected %b got %b",
                                 n_beats_seen, diff, want, out_data));
          n_updates += int'(want.update_strobe);
          n_lasts += int'(want.last);
        end
      end
    end
  end

  task automatic reg_access(input bit wr, input logic [PADDR_W-1:0] addr,
                            input logic [PDATA_W-1:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_repeats(input int reps);
    reg_access(1'b1, ADDR_REPEATS, (PDATA_W'($urandom) & ~REPS_MASK) | PDATA_W'(reps));
    reg_access(1'b0, ADDR_REPEATS, '0);
  endtask

  function automatic void push_cmd(input logic [1:0] op, input logic [4:0] row,
                                   input logic [4:0] col, input logic on);
    in_item_t item;
    item.op = op;
    item.pixel_row = row;
    item.pixel_col = col;
    item.pixel_on = on;
    cmd_queue.push_back(item);
    n_queued++;
  endfunction

  function automatic void push_random(input logic [1:0] op);
    push_cmd(op, 5'($urandom), 5'($urandom), 1'($urandom));
  endfunction

  function automatic void fill_pixels(input int count, input int pct_on);
    repeat (count)
      push_cmd(OP_WRITE, 5'($urandom), 5'($urandom), $urandom_range(1, 100) <= pct_on);
  endfunction

  // ticks with ignored or stray commands mixed in
  function automatic void push_ticks(input int count, input int pct_noise);
    repeat (count) begin
      if ($urandom_range(1, 100) <= pct_noise) begin
        case ($urandom_range(0, 2))
          0: push_random(OP_WRITE);
          1: push_random(OP_START);
          default: push_random(OP_NONE);
        endcase
      end
      push_random(OP_TICK);
    end
  endfunction

  task automatic drain();
    do @(posedge clk); while (n_taken != n_queued || tick_beats.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int waited;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // register port during the clearing pass
    reg_access(1'b0, ADDR_REPEATS, '0);
    reg_access(1'b1, ADDR_UNMAPPED, PDATA_W'(5));
    reg_access(1'b0, ADDR_REPEATS, '0);
    reg_access(1'b1, ADDR_REPEATS, ~REPS_MASK);
    reg_access(1'b0, ADDR_REPEATS, '0);

    // zero repeats, idle ticks, unused op, corner pixels, back to back
    no_gaps = 1'b1;
    push_random(OP_TICK);
    push_random(OP_NONE);
    push_random(OP_START);
    push_random(OP_TICK);
    push_cmd(OP_WRITE, 5'd0, 5'd0, 1'b1);
    push_cmd(OP_WRITE, 5'd0, 5'd31, 1'b1);
    push_cmd(OP_WRITE, 5'd31, 5'd0, 1'b1);
    push_cmd(OP_WRITE, 5'd31, 5'd31, 1'b1);
    push_cmd(OP_WRITE, 5'd15, 5'd15, 1'b1);
    push_cmd(OP_WRITE, 5'd16, 5'd16, 1'b1);
    push_cmd(OP_WRITE, 5'd15, 5'd16, 1'b1);
    push_cmd(OP_WRITE, 5'd16, 5'd15, 1'b1);
    push_cmd(OP_WRITE, 5'd31, 5'd31, 1'b0);
    drain();
    no_gaps = 1'b0;

    // two repeats, commands while transmitting are dropped
    set_repeats(2);
    fill_pixels(12, 40);
    push_random(OP_START);
    push_cmd(OP_WRITE, 5'd31, 5'd31, 1'b1);
    push_cmd(OP_WRITE, 5'd0, 5'd0, 1'b0);
    push_random(OP_START);
    push_random(OP_NONE);
    push_ticks(2 * TX_TICKS + 3, 1);
    drain();

    waited = 0;
    while ((n_taken != n_queued || tick_beats.size() != 0) && waited < 1000) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
    if (n_taken != n_queued)
      flag_error($sformatf("%0d commands never taken", n_queued - n_taken));
    if (tick_beats.size() != 0)
      flag_error($sformatf("%0d tick beats never arrived", tick_beats.size()));
    $display("%0d commands taken, %0d tick beats checked, %0d count bytes, %0d transmissions",
             n_taken, n_beats_seen, n_updates, n_lasts);
    $display("%0d register accesses, %0d errors", n_reg_access, n_errors);
    if (n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("cycle limit hit with %0d tick beats outstanding", tick_beats.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== quadrant_led_frame_serializer_unit.f =====
rtl/qlfs_pkg.sv
rtl/qlfs_ram.sv
rtl/qlfs_ctrl.sv
rtl/qlfs_dp.sv
rtl/quadrant_led_frame_serializer_unit.sv
rtl/qlfs_checker.sv
tb/tb_top.sv
